// File: src/hufd_pkg.sv
package hufd_pkg;

    // Sizes of the tree stores.
    localparam int MAX_NODES   = 512;
    localparam int STACK_DEPTH = 256;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int NFN_W       = NODE_W + 1;
    localparam int STK_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = STK_W + 1;
    localparam int FIFO_DEPTH  = 4;

    // Tree stream marker for a leaf.
    localparam logic [7:0] LEAF_MARK = 8'h31;

    // Opcodes of an input item.
    localparam logic OP_TREE = 1'b0;
    localparam logic OP_DATA = 1'b1;

    // Loader phases.
    localparam logic [1:0] PH_MARKER = 2'd0;
    localparam logic [1:0] PH_SYMBOL = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;
    localparam logic [1:0] PH_ERROR  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_SYMBOL = 2'd0;
    localparam logic [1:0] ST_NOTREE = 2'd1;
    localparam logic [1:0] ST_BADTREE = 2'd2;

    typedef struct packed {
        logic       opcode;
        logic [7:0] byte_value;
        logic [3:0] valid_bits;
    } item_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic [1:0] status;
        logic       last;
    } result_t;

    // Classified command passed from front to back.
    typedef struct packed {
        logic       is_data;
        logic [7:0] byte_value;
        logic [3:0] nbits;
    } cmd_t;

endpackage

// File: src/hufd_fifo.sv
module hufd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hufd_pkg::cmd_t    wdata,
    output logic              full,
    input  logic              pop,
    output hufd_pkg::cmd_t    head,
    output logic              empty
);

    localparam int PTR_W = $clog2(hufd_pkg::FIFO_DEPTH);

    hufd_pkg::cmd_t   slot_reg [hufd_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (PTR_W+1)'(hufd_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: src/hufd_front.sv
module hufd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  hufd_pkg::item_t item,
    output logic            cmd_push,
    output hufd_pkg::cmd_t  cmd,
    input  logic            cmd_full
);

    logic           hold_valid_reg;
    hufd_pkg::cmd_t hold_reg;
    hufd_pkg::cmd_t class_cmd;

    // Classify the item and clamp the bit count to one byte.
    always_comb
    begin
        class_cmd.is_data    = (item.opcode == hufd_pkg::OP_DATA);
        class_cmd.byte_value = item.byte_value;
        class_cmd.nbits      = (item.valid_bits > 4'd8) ? 4'd8 : item.valid_bits;
    end

    assign item_stall = hold_valid_reg && cmd_full;
    assign cmd_push   = hold_valid_reg;
    assign cmd        = hold_reg;

    // One holding register in front of the queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            hold_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
        begin
            hold_reg <= class_cmd;
        end
    end

endmodule

// File: src/hufd_back.sv
module hufd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  hufd_pkg::cmd_t    cmd,
    input  logic              cmd_empty,
    output logic              cmd_pop,
    output hufd_pkg::result_t result,
    output logic              result_valid,
    input  logic              result_stall
);

    localparam int NODE_W = hufd_pkg::NODE_W;
    localparam int NFN_W  = hufd_pkg::NFN_W;
    localparam int STK_W  = hufd_pkg::STK_W;
    localparam int CNT_W  = hufd_pkg::CNT_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_TREE  = 7'b0000010,
        S_PUSH  = 7'b0000100,
        S_RDCH  = 7'b0001000,
        S_RDLF  = 7'b0010000,
        S_EVAL  = 7'b0100000,
        S_FLUSH = 7'b1000000
    } state_t;

    // Node and stack memories.
    logic [8:0]        leafsym_mem [hufd_pkg::MAX_NODES];
    logic [NODE_W-1:0] left_mem    [hufd_pkg::MAX_NODES];
    logic [NODE_W-1:0] right_mem   [hufd_pkg::MAX_NODES];
    logic [NODE_W:0]   stack_mem   [hufd_pkg::STACK_DEPTH];

    logic [8:0]        ls_rd_reg;
    logic [NODE_W-1:0] left_rd_reg;
    logic [NODE_W-1:0] right_rd_reg;
    logic [NODE_W:0]   stk_rd_reg;

    logic              ls_we;
    logic [NODE_W-1:0] ls_waddr;
    logic [8:0]        ls_wdata;
    logic              ls_re;
    logic [NODE_W-1:0] ls_raddr;
    logic              l_we;
    logic              r_we;
    logic [NODE_W-1:0] lr_waddr;
    logic [NODE_W-1:0] lr_wdata;
    logic              lr_re;
    logic [NODE_W-1:0] lr_raddr;
    logic              stk_we;
    logic [STK_W-1:0]  stk_waddr;
    logic [NODE_W:0]   stk_wdata;
    logic              stk_re;
    logic [STK_W-1:0]  stk_raddr;

    // Control registers.
    state_t            state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [NFN_W-1:0]  nfn_reg, nfn_next;
    logic [NODE_W-1:0] walk_reg, walk_next;
    logic [NODE_W-1:0] child_reg, child_next;
    logic [NODE_W-1:0] pend_n_reg, pend_n_next;
    logic [7:0]        byte_reg, byte_next;
    logic [3:0]        left_bits_reg, left_bits_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [7:0]        pend_sym_reg, pend_sym_next;
    logic              root_leaf_reg;
    logic [7:0]        root_sym_reg;
    logic              out_valid_reg;
    hufd_pkg::result_t out_reg;

    logic              out_free;
    logic              push_en;
    hufd_pkg::result_t push_data;
    logic              prod_en;
    logic [7:0]        prod_sym;
    logic              prod_blocked;
    logic [NODE_W-1:0] new_n;
    logic [NODE_W-1:0] top_idx;
    logic [NODE_W-1:0] child_sel;

    assign out_free     = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign new_n        = nfn_reg[NODE_W-1:0];
    assign top_idx      = stk_rd_reg[NODE_W:1];
    assign child_sel    = byte_reg[7] ? right_rd_reg : left_rd_reg;
    assign prod_blocked = pend_valid_reg && !out_free;

    // Sequencer for tree building and the bit walk.
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        nfn_next        = nfn_reg;
        walk_next       = walk_reg;
        child_next      = child_reg;
        pend_n_next     = pend_n_reg;
        byte_next       = byte_reg;
        left_bits_next  = left_bits_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        cmd_pop         = 1'b0;
        push_en         = 1'b0;
        push_data       = '0;
        prod_en         = 1'b0;
        prod_sym        = root_sym_reg;
        ls_we           = 1'b0;
        ls_waddr        = new_n;
        ls_wdata        = '0;
        ls_re           = 1'b0;
        ls_raddr        = child_sel;
        l_we            = 1'b0;
        r_we            = 1'b0;
        lr_waddr        = top_idx;
        lr_wdata        = new_n;
        lr_re           = 1'b0;
        lr_raddr        = walk_reg;
        stk_we          = 1'b0;
        stk_waddr       = STK_W'(cnt_reg - 1'b1);
        stk_wdata       = stk_rd_reg | (NODE_W+1)'(1);
        stk_re          = 1'b0;
        stk_raddr       = STK_W'(cnt_reg - 1'b1);

        case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    if (!cmd.is_data)
                    begin
                        cmd_pop   = 1'b1;
                        byte_next = cmd.byte_value;
                        stk_re    = 1'b1;
                        if (phase_reg == hufd_pkg::PH_DONE || phase_reg == hufd_pkg::PH_ERROR)
                        begin
                            cnt_next   = '0;
                            nfn_next   = '0;
                            walk_next  = '0;
                            phase_next = hufd_pkg::PH_MARKER;
                        end
                        state_next = S_TREE;
                    end
                    else if (phase_reg != hufd_pkg::PH_DONE)
                    begin
                        if (out_free)
                        begin
                            cmd_pop   = 1'b1;
                            push_en   = 1'b1;
                            push_data = '{symbol: 8'd0, status: hufd_pkg::ST_NOTREE,
                                          last: 1'b1};
                        end
                    end
                    else
                    begin
                        cmd_pop        = 1'b1;
                        byte_next      = cmd.byte_value;
                        left_bits_next = cmd.nbits;
                        if (cmd.nbits != 4'd0)
                        begin
                            state_next = S_RDCH;
                        end
                    end
                end
            end

            S_TREE:
            begin
                if (phase_reg == hufd_pkg::PH_SYMBOL)
                begin
                    ls_we      = 1'b1;
                    ls_waddr   = NODE_W'(nfn_reg - 1'b1);
                    ls_wdata   = {1'b1, byte_reg};
                    phase_next = (cnt_reg == '0) ? hufd_pkg::PH_DONE : hufd_pkg::PH_MARKER;
                    state_next = S_IDLE;
                end
                else if (nfn_reg >= NFN_W'(hufd_pkg::MAX_NODES) ||
                         (byte_reg != hufd_pkg::LEAF_MARK &&
                          cnt_reg >= CNT_W'(hufd_pkg::STACK_DEPTH)))
                begin
                    if (out_free)
                    begin
                        push_en    = 1'b1;
                        push_data  = '{symbol: 8'd0, status: hufd_pkg::ST_BADTREE,
                                       last: 1'b1};
                        phase_next = hufd_pkg::PH_ERROR;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    nfn_next = nfn_reg + 1'b1;
                    ls_we    = 1'b1;
                    ls_wdata = {(byte_reg == hufd_pkg::LEAF_MARK), 8'd0};
                    // Hook the new node under the pending parent.
                    if (cnt_reg != '0)
                    begin
                        if (!stk_rd_reg[0])
                        begin
                            l_we   = 1'b1;
                            stk_we = 1'b1;
                        end
                        else
                        begin
                            r_we     = 1'b1;
                            cnt_next = cnt_reg - 1'b1;
                        end
                    end
                    if (byte_reg == hufd_pkg::LEAF_MARK)
                    begin
                        phase_next = hufd_pkg::PH_SYMBOL;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pend_n_next = new_n;
                        state_next  = S_PUSH;
                    end
                end
            end

            S_PUSH:
            begin
                stk_we     = 1'b1;
                stk_waddr  = cnt_reg[STK_W-1:0];
                stk_wdata  = {pend_n_reg, 1'b0};
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_IDLE;
            end

            S_RDCH:
            begin
                if (root_leaf_reg)
                begin
                    prod_en  = 1'b1;
                    prod_sym = root_sym_reg;
                    if (!prod_blocked)
                    begin
                        walk_next      = '0;
                        byte_next      = {byte_reg[6:0], 1'b0};
                        left_bits_next = left_bits_reg - 1'b1;
                        state_next     = (left_bits_reg == 4'd1) ? S_FLUSH : S_RDCH;
                    end
                end
                else
                begin
                    lr_re      = 1'b1;
                    state_next = S_RDLF;
                end
            end

            S_RDLF:
            begin
                ls_re      = 1'b1;
                child_next = child_sel;
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                if (ls_rd_reg[8])
                begin
                    prod_en  = 1'b1;
                    prod_sym = ls_rd_reg[7:0];
                end
                if (!(prod_en && prod_blocked))
                begin
                    walk_next      = ls_rd_reg[8] ? '0 : child_reg;
                    byte_next      = {byte_reg[6:0], 1'b0};
                    left_bits_next = left_bits_reg - 1'b1;
                    state_next     = (left_bits_reg == 4'd1) ? S_FLUSH : S_RDCH;
                end
            end

            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    push_en         = 1'b1;
                    push_data       = '{symbol: pend_sym_reg, status: hufd_pkg::ST_SYMBOL,
                                        last: 1'b1};
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A new symbol sends the held one out, since it cannot be the last.
        if (prod_en && !prod_blocked)
        begin
            if (pend_valid_reg)
            begin
                push_en   = 1'b1;
                push_data = '{symbol: pend_sym_reg, status: hufd_pkg::ST_SYMBOL,
                              last: 1'b0};
            end
            pend_valid_next = 1'b1;
            pend_sym_next   = prod_sym;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= hufd_pkg::PH_MARKER;
            cnt_reg        <= '0;
            nfn_reg        <= '0;
            walk_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            left_bits_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            nfn_reg        <= nfn_next;
            walk_reg       <= walk_next;
            pend_valid_reg <= pend_valid_next;
            left_bits_reg  <= left_bits_next;
            if (push_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        child_reg    <= child_next;
        pend_n_reg   <= pend_n_next;
        byte_reg     <= byte_next;
        pend_sym_reg <= pend_sym_next;
        if (push_en)
        begin
            out_reg <= push_data;
        end
        if (ls_we && ls_waddr == '0)
        begin
            root_leaf_reg <= ls_wdata[8];
            root_sym_reg  <= ls_wdata[7:0];
        end
    end

    // Leaf flag and symbol store.
    always_ff @(posedge clk)
    begin
        if (ls_we)
        begin
            leafsym_mem[ls_waddr] <= ls_wdata;
        end
        if (ls_re)
        begin
            ls_rd_reg <= leafsym_mem[ls_raddr];
        end
    end

    // Child link stores.
    always_ff @(posedge clk)
    begin
        if (l_we)
        begin
            left_mem[lr_waddr] <= lr_wdata;
        end
        if (r_we)
        begin
            right_mem[lr_waddr] <= lr_wdata;
        end
        if (lr_re)
        begin
            left_rd_reg  <= left_mem[lr_raddr];
            right_rd_reg <= right_mem[lr_raddr];
        end
    end

    // Stack of pending parents.
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stack_mem[stk_raddr];
        end
    end

    // A complete tree has no open parents.
    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == hufd_pkg::PH_DONE |-> cnt_reg == '0)
        else $error("complete tree with open parents");

    // The stack never holds more than its depth.
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(hufd_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    // No symbol is held back once a data item is finished.
    a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("symbol left pending at idle");

    // A symbol byte always has a leaf node to land in.
    a_symbol_node: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == hufd_pkg::PH_SYMBOL |-> nfn_reg != '0)
        else $error("symbol phase with no node");

    // An output held under stall keeps its item.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_stall |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result changed");

endmodule

// File: src/huffman_tree_decoder_core.sv
// A tree byte passes the front holding register and the command queue; the back end takes
// it in S_IDLE, builds its node in S_TREE and, for an inner node, pushes it in S_PUSH. A
// rejected data item shows its result in the output register once taken. Each code bit of a
// data byte runs through S_RDCH, S_RDLF and S_EVAL (two dependent node-memory reads per bit),
// and S_FLUSH sends its last symbol; a single-leaf tree needs only S_RDCH per bit.
// Reset clears all control state; the tree is empty and the node memories are not cleared.
module huffman_tree_decoder_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  hufd_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output hufd_pkg::result_t result
);

    logic           cmd_push;
    logic           cmd_full;
    logic           cmd_pop;
    logic           cmd_empty;
    hufd_pkg::cmd_t cmd_in;
    hufd_pkg::cmd_t cmd_head;

    // Front end: accepts and classifies items.
    hufd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cmd_push   (cmd_push),
        .cmd        (cmd_in),
        .cmd_full   (cmd_full)
    );

    // Command queue between the two halves.
    hufd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .head  (cmd_head),
        .empty (cmd_empty)
    );

    // Back end: tree builder and bit walker.
    hufd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_head),
        .cmd_empty    (cmd_empty),
        .cmd_pop      (cmd_pop),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule
